// File: rtl/twodom_pkg.sv
// Package for the tracking wheel odometry core: payload structs, datapath commands,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
package twodom_pkg;

    typedef enum logic [0:0] {
        CFG_FWD_OFFSET  = 1'b0,
        CFG_SIDE_OFFSET = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] forward_angle;
        logic signed [31:0] strafe_angle;
        logic [15:0]        gyro_heading;
    } t_sample;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [15:0]        heading_out;
    } t_result;

    typedef struct packed {
        t_cfg_idx           reg_index;
        logic signed [15:0] wdata;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DF,
        OP_MUL_DS,
        OP_MUL_DH,
        OP_MUL_MID,
        OP_MUL_OFF_F,
        OP_MUL_OFF_S,
        OP_SET_CS,
        OP_CORD_HALF,
        OP_CORD_MID,
        OP_CORD_STEP,
        OP_CORD_NEG,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FAC,
        OP_MQ_HI,
        OP_MQ_LO,
        OP_MQ_FIN,
        OP_UPDATE
    } t_dp_op;

    typedef enum logic [0:0] {A_LX, A_LY} t_a_sel;
    typedef enum logic [1:0] {B_FAC, B_COS, B_SIN} t_b_sel;
    typedef enum logic [2:0] {D_LX, D_LY, D_FX_SET, D_FX_ADD, D_FY_SET, D_FY_SUB} t_dst;

    typedef struct packed {
        t_dp_op     op;
        t_a_sel     a_sel;
        t_b_sel     b_sel;
        t_dst       dst;
        logic [5:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic dh_zero;
    } t_dp_status;

    localparam logic [15:0]        HEADING_FULL = 16'd36000;
    localparam logic signed [33:0] RAD_Q40      = 34'sd191900981;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [33:0] FAC_ONE      = 34'sd1073741824;
    localparam logic signed [47:0] POS_MAX      = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] POS_MIN      = 48'sh8000_0000_0000;
    localparam int                 DIV_STEPS    = 62;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021685;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd31: v = 30'd0;
            default: v = 30'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

// File: rtl/twodom_if.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on twodom_pkg for the payload types.
interface twodom_sample_if;
    import twodom_pkg::*;
    logic    valid;
    logic    ready;
    t_sample data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface twodom_result_if;
    import twodom_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface twodom_cfg_if;
    import twodom_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/twodom_dp.sv
// Odometry datapath: shared 34x34 multiplier, CORDIC rotator, restoring divider,
// state and offset registers. Executes one command per cycle; depends on twodom_pkg.
module twodom_dp import twodom_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  t_sample    i_sample,
    input  logic       i_cfg_we,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic signed [15:0] r_foff, r_soff;
    logic signed [31:0] r_last_f, r_last_s;
    logic [15:0]        r_last_h, r_hd, r_out_h;
    logic signed [32:0] r_dfa, r_dsa;
    logic signed [15:0] r_dh, r_a2;
    logic               r_neg;
    logic signed [67:0] r_prod, r_t;
    logic signed [39:0] r_df, r_ds;
    logic signed [33:0] r_dhrad, r_half, r_mid, r_cx, r_cy, r_cz, r_fac, r_mb;
    logic signed [47:0] r_lx, r_ly, r_ma, r_field_x, r_field_y;
    logic signed [49:0] r_fx, r_fy;
    logic [61:0]        r_dq;
    logic [31:0]        r_dr, r_dd;
    logic               r_dsign;

    logic [15:0]        hd_in;
    logic signed [16:0] dh_raw, dh_w;
    logic signed [19:0] a2_raw, a2_b, a2_f;
    logic               a2_neg;
    logic signed [47:0] a_mux;
    logic signed [33:0] b_mux, m_a, m_b;
    logic signed [67:0] m_p, mq;
    logic [4:0]         cidx;
    logic signed [33:0] xs, ys, at, hs_abs, half_abs, qm;
    logic [32:0]        rs, rdiff;
    logic               ge;
    logic signed [50:0] sum_x, sum_y;

    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v > 51'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < 51'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = 48'(v);
        end
        return r;
    endfunction

    always_comb begin
        hd_in = (i_sample.gyro_heading >= HEADING_FULL) ?
                i_sample.gyro_heading - HEADING_FULL : i_sample.gyro_heading;
        dh_raw = $signed({1'b0, hd_in}) - $signed({1'b0, r_last_h});
        dh_w = dh_raw;
        if (dh_raw > 17'sd18000) begin
            dh_w = dh_raw - 17'sd36000;
        end else if (dh_raw < -17'sd18000) begin
            dh_w = dh_raw + 17'sd36000;
        end

        a2_raw = $signed({3'b0, r_hd, 1'b0}) - 20'(r_dh);
        a2_b = a2_raw;
        if (a2_raw > 20'sd36000) begin
            a2_b = a2_raw - 20'sd72000;
        end else if (a2_raw <= -20'sd36000) begin
            a2_b = a2_raw + 20'sd72000;
        end
        a2_f = a2_b;
        a2_neg = 1'b0;
        if (a2_b > 20'sd18000) begin
            a2_f = a2_b - 20'sd36000;
            a2_neg = 1'b1;
        end else if (a2_b < -20'sd18000) begin
            a2_f = a2_b + 20'sd36000;
            a2_neg = 1'b1;
        end
    end

    always_comb begin
        a_mux = (i_cmd.a_sel == A_LX) ? r_lx : r_ly;
        case (i_cmd.b_sel)
            B_FAC:   b_mux = r_fac;
            B_COS:   b_mux = r_cx;
            B_SIN:   b_mux = r_cy;
            default: b_mux = r_fac;
        endcase
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_MUL_DF: begin
                m_a = 34'(r_dfa);
                m_b = RAD_Q40;
            end
            OP_MUL_DS: begin
                m_a = 34'(r_dsa);
                m_b = RAD_Q40;
            end
            OP_MUL_DH: begin
                m_a = 34'(r_dh);
                m_b = RAD_Q40;
            end
            OP_MUL_MID: begin
                m_a = 34'(r_a2);
                m_b = RAD_Q40;
            end
            OP_MUL_OFF_F: begin
                m_a = 34'(r_foff);
                m_b = r_dhrad;
            end
            OP_MUL_OFF_S: begin
                m_a = 34'(r_soff);
                m_b = r_dhrad;
            end
            OP_MQ_HI: begin
                m_a = 34'(a_mux >>> 16);
                m_b = b_mux;
            end
            OP_MQ_LO: begin
                m_a = $signed({18'b0, r_ma[15:0]});
                m_b = r_mb;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;
    assign mq = (r_t + (r_prod >>> 16) + 68'sd8192) >>> 14;

    assign cidx = i_cmd.idx[4:0];
    assign xs = r_cx >>> cidx;
    assign ys = r_cy >>> cidx;
    assign at = $signed({4'b0, atan_q30(cidx)});

    assign hs_abs = r_cy[33] ? -r_cy : r_cy;
    assign half_abs = r_half[33] ? -r_half : r_half;
    assign rs = {r_dr, r_dq[61]};
    assign rdiff = rs - {1'b0, r_dd};
    assign ge = (rs >= {1'b0, r_dd});
    assign qm = $signed({1'b0, r_dq[32:0]});

    assign sum_x = 51'(r_field_x) + 51'(r_fx);
    assign sum_y = 51'(r_field_y) + 51'(r_fy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foff    <= 16'sd320;
            r_soff    <= 16'sd742;
            r_last_f  <= '0;
            r_last_s  <= '0;
            r_last_h  <= '0;
            r_field_x <= '0;
            r_field_y <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg.reg_index)
                    CFG_FWD_OFFSET:  r_foff <= i_cfg.wdata;
                    CFG_SIDE_OFFSET: r_soff <= i_cfg.wdata;
                    default: ;
                endcase
            end
            r_prod <= m_p;
            case (i_cmd.op)
                OP_LOAD: begin
                    r_dfa    <= 33'(i_sample.forward_angle) - 33'(r_last_f);
                    r_dsa    <= 33'(i_sample.strafe_angle) - 33'(r_last_s);
                    r_dh     <= 16'(dh_w);
                    r_hd     <= hd_in;
                    r_last_f <= i_sample.forward_angle;
                    r_last_s <= i_sample.strafe_angle;
                    r_last_h <= hd_in;
                end
                OP_MUL_DF: begin
                    r_a2  <= 16'(a2_f);
                    r_neg <= a2_neg;
                end
                OP_MUL_DS: r_df <= 40'((r_prod + 68'sd8388608) >>> 24);
                OP_MUL_DH: r_ds <= 40'((r_prod + 68'sd8388608) >>> 24);
                OP_MUL_MID: begin
                    r_dhrad <= 34'((r_prod + 68'sd512) >>> 10);
                    r_half  <= 34'((r_prod + 68'sd1024) >>> 11);
                end
                OP_MUL_OFF_F: r_mid <= 34'((r_prod + 68'sd1024) >>> 11);
                OP_MUL_OFF_S: r_lx <= 48'(68'(r_df) - ((r_prod + 68'sd2097152) >>> 22));
                OP_SET_CS: r_ly <= 48'(68'(r_ds) - ((r_prod + 68'sd2097152) >>> 22));
                OP_CORD_HALF: begin
                    r_cx <= CORDIC_GAIN;
                    r_cy <= '0;
                    r_cz <= r_half;
                end
                OP_CORD_MID: begin
                    r_cx <= CORDIC_GAIN;
                    r_cy <= '0;
                    r_cz <= r_mid;
                end
                OP_CORD_STEP: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - at;
                    end else begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + at;
                    end
                end
                OP_CORD_NEG: begin
                    if (r_neg) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                end
                OP_DIV_INIT: begin
                    r_dq    <= {hs_abs[31:0], 30'b0};
                    r_dd    <= half_abs[31:0];
                    r_dr    <= '0;
                    r_dsign <= r_cy[33] ^ r_half[33];
                end
                OP_DIV_STEP: begin
                    r_dr <= ge ? rdiff[31:0] : rs[31:0];
                    r_dq <= {r_dq[60:0], ge};
                end
                OP_FAC: begin
                    if (r_dd == '0) begin
                        r_fac <= FAC_ONE;
                    end else begin
                        r_fac <= r_dsign ? -qm : qm;
                    end
                end
                OP_MQ_HI: begin
                    r_ma <= a_mux;
                    r_mb <= b_mux;
                end
                OP_MQ_LO: r_t <= r_prod;
                OP_MQ_FIN: begin
                    case (i_cmd.dst)
                        D_LX:     r_lx <= 48'(mq);
                        D_LY:     r_ly <= 48'(mq);
                        D_FX_SET: r_fx <= 50'(mq);
                        D_FX_ADD: r_fx <= r_fx + 50'(mq);
                        D_FY_SET: r_fy <= 50'(mq);
                        D_FY_SUB: r_fy <= r_fy - 50'(mq);
                        default: ;
                    endcase
                end
                OP_UPDATE: begin
                    r_field_x <= sat48(sum_x);
                    r_field_y <= sat48(sum_y);
                    r_out_h   <= r_hd;
                end
                default: ;
            endcase
        end
    end

    assign o_status.dh_zero = (r_dh == 16'sd0);
    assign o_result.pos_x = r_field_x;
    assign o_result.pos_y = r_field_y;
    assign o_result.heading_out = r_out_h;

endmodule

// File: rtl/twodom_ctrl.sv
// Odometry controller: state machine that sequences the datapath commands for one
// sample and owns the sample and result handshakes. Depends on twodom_pkg.
module twodom_ctrl import twodom_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_MDF, ST_MDS, ST_MDH, ST_MMID, ST_MOF, ST_MOS, ST_CS,
        ST_ARC_INIT, ST_ARC_STEP, ST_DIV_INIT, ST_DIV_STEP, ST_FAC,
        ST_MQ_HI, ST_MQ_LO, ST_MQ_FIN, ST_ROT_INIT, ST_ROT_STEP, ST_ROT_NEG,
        ST_UPDATE
    } t_state;

    typedef enum logic [2:0] {J_LX, J_LY, J_FX1, J_FX2, J_FY1, J_FY2} t_job;

    localparam logic [5:0] LAST_CORD = 6'(CORDIC_STEPS - 1);
    localparam logic [5:0] LAST_DIV  = 6'(DIV_STEPS - 1);

    t_state     r_state;
    t_job       r_job;
    logic [5:0] r_cnt;
    logic       r_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.op = OP_NONE;
        o_cmd.idx = r_cnt;
        case (r_job)
            J_LX: begin
                o_cmd.a_sel = A_LX;
                o_cmd.b_sel = B_FAC;
                o_cmd.dst = D_LX;
            end
            J_LY: begin
                o_cmd.a_sel = A_LY;
                o_cmd.b_sel = B_FAC;
                o_cmd.dst = D_LY;
            end
            J_FX1: begin
                o_cmd.a_sel = A_LX;
                o_cmd.b_sel = B_COS;
                o_cmd.dst = D_FX_SET;
            end
            J_FX2: begin
                o_cmd.a_sel = A_LY;
                o_cmd.b_sel = B_SIN;
                o_cmd.dst = D_FX_ADD;
            end
            J_FY1: begin
                o_cmd.a_sel = A_LY;
                o_cmd.b_sel = B_COS;
                o_cmd.dst = D_FY_SET;
            end
            J_FY2: begin
                o_cmd.a_sel = A_LX;
                o_cmd.b_sel = B_SIN;
                o_cmd.dst = D_FY_SUB;
            end
            default: begin
                o_cmd.a_sel = A_LX;
                o_cmd.b_sel = B_FAC;
                o_cmd.dst = D_LX;
            end
        endcase
        case (r_state)
            ST_IDLE:     o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            ST_MDF:      o_cmd.op = OP_MUL_DF;
            ST_MDS:      o_cmd.op = OP_MUL_DS;
            ST_MDH:      o_cmd.op = OP_MUL_DH;
            ST_MMID:     o_cmd.op = OP_MUL_MID;
            ST_MOF:      o_cmd.op = OP_MUL_OFF_F;
            ST_MOS:      o_cmd.op = OP_MUL_OFF_S;
            ST_CS:       o_cmd.op = OP_SET_CS;
            ST_ARC_INIT: o_cmd.op = OP_CORD_HALF;
            ST_ARC_STEP: o_cmd.op = OP_CORD_STEP;
            ST_DIV_INIT: o_cmd.op = OP_DIV_INIT;
            ST_DIV_STEP: o_cmd.op = OP_DIV_STEP;
            ST_FAC:      o_cmd.op = OP_FAC;
            ST_MQ_HI:    o_cmd.op = OP_MQ_HI;
            ST_MQ_LO:    o_cmd.op = OP_MQ_LO;
            ST_MQ_FIN:   o_cmd.op = OP_MQ_FIN;
            ST_ROT_INIT: o_cmd.op = OP_CORD_MID;
            ST_ROT_STEP: o_cmd.op = OP_CORD_STEP;
            ST_ROT_NEG:  o_cmd.op = OP_CORD_NEG;
            ST_UPDATE:   o_cmd.op = out_free ? OP_UPDATE : OP_NONE;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_job       <= J_LX;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_UPDATE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE:  if (i_in_valid) r_state <= ST_MDF;
                ST_MDF:   r_state <= ST_MDS;
                ST_MDS:   r_state <= ST_MDH;
                ST_MDH:   r_state <= ST_MMID;
                ST_MMID:  r_state <= ST_MOF;
                ST_MOF:   r_state <= ST_MOS;
                ST_MOS:   r_state <= ST_CS;
                ST_CS:    r_state <= i_status.dh_zero ? ST_ROT_INIT : ST_ARC_INIT;
                ST_ARC_INIT: begin
                    r_cnt   <= '0;
                    r_state <= ST_ARC_STEP;
                end
                ST_ARC_STEP: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_CORD) r_state <= ST_DIV_INIT;
                end
                ST_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV_STEP;
                end
                ST_DIV_STEP: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_DIV) r_state <= ST_FAC;
                end
                ST_FAC: begin
                    r_job   <= J_LX;
                    r_state <= ST_MQ_HI;
                end
                ST_MQ_HI: r_state <= ST_MQ_LO;
                ST_MQ_LO: r_state <= ST_MQ_FIN;
                ST_MQ_FIN: begin
                    case (r_job)
                        J_LX: begin
                            r_job   <= J_LY;
                            r_state <= ST_MQ_HI;
                        end
                        J_LY:  r_state <= ST_ROT_INIT;
                        J_FX1: begin
                            r_job   <= J_FX2;
                            r_state <= ST_MQ_HI;
                        end
                        J_FX2: begin
                            r_job   <= J_FY1;
                            r_state <= ST_MQ_HI;
                        end
                        J_FY1: begin
                            r_job   <= J_FY2;
                            r_state <= ST_MQ_HI;
                        end
                        J_FY2:   r_state <= ST_UPDATE;
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_ROT_INIT: begin
                    r_cnt   <= '0;
                    r_state <= ST_ROT_STEP;
                end
                ST_ROT_STEP: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_CORD) r_state <= ST_ROT_NEG;
                end
                ST_ROT_NEG: begin
                    r_job   <= J_FX1;
                    r_state <= ST_MQ_HI;
                end
                ST_UPDATE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/tracking_wheel_odometry_core.sv
// Tracking wheel arc odometry core. A sample occupies the core until its result is
// registered. When the heading is unchanged the arc CORDIC pass, the bit-serial divider
// and the arc scaling are skipped; otherwise both passes of the shared CORDIC run.
// The next sample is taken in the cycle after the result is registered, even while it
// waits on the output. Reset is synchronous, active low: position, last sample and
// heading clear to zero and the wheel offsets return to 1.25 in and 2.9 in.
module tracking_wheel_odometry_core import twodom_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    twodom_sample_if.sink    i_sample,
    twodom_result_if.source  o_result,
    twodom_cfg_if.sink       i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;
    logic       out_valid;
    t_result    result;

    assign i_cfg.ready = 1'b1;
    assign i_sample.ready = in_ready;
    assign o_result.valid = out_valid;
    assign o_result.data = result;

    twodom_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    twodom_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_sample (i_sample.data),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .o_result (result)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("sample accepted while a transaction is in progress");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.data.heading_out < HEADING_FULL))
        else $error("heading output out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_UPDATE) |-> (!o_result.valid || o_result.ready))
        else $error("position updated while a result transaction is pending");
`endif

endmodule

// File: tb/tracking_wheel_odometry_core_test.sv
// Testbench for tracking_wheel_odometry_core: directed and random samples under several
// wheel offset settings, each result checked against a fixed-point odometry predictor or a
// directed table entry. Depends on twodom_pkg and the channel interfaces in twodom_if.sv.
module tracking_wheel_odometry_core_test;
    import twodom_pkg::*;

    localparam int     CORDIC_STEPS = 24;
    localparam int     PHASE_ITEMS  = 376;
    localparam int     CALM_ITEMS   = 250;
    localparam longint CYCLE_LIMIT  = 3000000;
    localparam longint DEG2RAD_Q40  = 191900981;
    localparam longint GAIN_Q30     = 652032874;
    localparam longint ONE_Q30      = 64'sd1073741824;
    localparam longint FIELD_MAX    = 64'sd140737488355327;
    localparam longint FIELD_MIN    = -64'sd140737488355328;

    typedef struct {
        logic signed [31:0] fwd;
        logic signed [31:0] strafe;
        logic [15:0]        hdg;
        bit                 known;
        t_result            res;
    } t_row;

    logic   i_clk;
    logic   i_rst_n;
    longint cycles;
    int     errors;
    bit     calm;
    bit     hold_req;

    longint arc_tab [0:31] = '{
        843314857, 497837829, 263043837, 133525159, 67021685, 33543516, 16775851,
        8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    longint fwd_offset, side_offset, prev_fwd, prev_strafe, prev_hdg, field_x, field_y;
    t_result expected_pose [$];

    t_row dir_tab [0:19] = '{
        '{32'sd0, 32'sd0, 16'd0, 1'b1, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd36000, 1'b1, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd18000, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd0, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd35999, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd1, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd65535, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sh7FFFFFFF, 32'sd0, 16'd0, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sh80000000, 32'sd0, 16'd0, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sh7FFFFFFF, 16'd0, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sh80000000, 16'd0, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'd9000, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sh80000000, 32'sh80000000, 16'd27000, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd100, -32'sd100, 16'd27000, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd36000, 32'sd36000, 16'd0, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd17999, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd35999, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd0, 32'sd0, 16'd18000, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd12345, -32'sd6789, 16'd4500, 1'b0, '{48'sd0, 48'sd0, 16'd0}},
        '{32'sd12345, -32'sd6789, 16'd4500, 1'b0, '{48'sd0, 48'sd0, 16'd0}}
    };

    twodom_sample_if s_if ();
    twodom_result_if r_if ();
    twodom_cfg_if    c_if ();

    tracking_wheel_odometry_core #(.CORDIC_STEPS(CORDIC_STEPS)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (s_if),
        .o_result (r_if),
        .i_cfg    (c_if)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint mul_q30(longint a, longint b);
        longint hi, lo, t;
        hi = a >>> 16;
        lo = a - hi * 65536;
        t  = hi * b + ((lo * b) >>> 16);
        return (t + 8192) >>> 14;
    endfunction

    function automatic void rotate_unit(longint z, output longint c, output longint s);
        longint x, y, xs, ys;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arc_tab[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arc_tab[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint clamp_field(longint v);
        if (v > FIELD_MAX) return FIELD_MAX;
        if (v < FIELD_MIN) return FIELD_MIN;
        return v;
    endfunction

    function automatic t_result odom_advance(t_sample smp);
        longint fa, sa, hd, dh, dh_rad, df, ds, cf, cs, lx, ly, a2, half, hc, hs, fac;
        longint cz, sz, fx, fy;
        bit flip;
        t_result r;
        fa = longint'($signed(smp.forward_angle));
        sa = longint'($signed(smp.strafe_angle));
        hd = longint'(smp.gyro_heading) % 36000;
        df = ((fa - prev_fwd) * DEG2RAD_Q40 + 64'sd8388608) >>> 24;
        ds = ((sa - prev_strafe) * DEG2RAD_Q40 + 64'sd8388608) >>> 24;
        dh = hd - prev_hdg;
        if (dh > 18000) dh = dh - 36000;
        if (dh < -18000) dh = dh + 36000;
        prev_fwd = fa;
        prev_strafe = sa;
        prev_hdg = hd;
        dh_rad = (dh * DEG2RAD_Q40 + 512) >>> 10;
        cf = df - ((fwd_offset * dh_rad + 64'sd2097152) >>> 22);
        cs = ds - ((side_offset * dh_rad + 64'sd2097152) >>> 22);
        if (dh == 0) begin
            lx = cf;
            ly = cs;
        end else begin
            half = (dh * DEG2RAD_Q40 + 1024) >>> 11;
            rotate_unit(half, hc, hs);
            fac = (half != 0) ? (hs * ONE_Q30) / half : ONE_Q30;
            lx = mul_q30(cf, fac);
            ly = mul_q30(cs, fac);
        end
        flip = 1'b0;
        a2 = 2 * hd - dh;
        if (a2 > 36000) a2 = a2 - 72000;
        if (a2 <= -36000) a2 = a2 + 72000;
        if (a2 > 18000) begin
            a2 = a2 - 36000;
            flip = 1'b1;
        end else if (a2 < -18000) begin
            a2 = a2 + 36000;
            flip = 1'b1;
        end
        rotate_unit((a2 * DEG2RAD_Q40 + 1024) >>> 11, cz, sz);
        if (flip) begin
            cz = -cz;
            sz = -sz;
        end
        fx = mul_q30(lx, cz) + mul_q30(ly, sz);
        fy = mul_q30(ly, cz) - mul_q30(lx, sz);
        field_x = clamp_field(field_x + fx);
        field_y = clamp_field(field_y + fy);
        r.pos_x = field_x[47:0];
        r.pos_y = field_y[47:0];
        r.heading_out = hd[15:0];
        return r;
    endfunction

    task automatic offer_sample(input t_sample smp, input bit known, input t_result typed);
        t_result p;
        s_if.data = smp;
        s_if.valid = 1'b1;
        do @(posedge i_clk); while (!s_if.ready);
        p = odom_advance(smp);
        expected_pose.push_back(known ? typed : p);
        @(negedge i_clk);
        s_if.valid = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 14)) @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (expected_pose.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_offset(input t_cfg_idx idx, input logic signed [15:0] v);
        c_if.data.reg_index = idx;
        c_if.data.wdata = v;
        c_if.valid = 1'b1;
        do @(posedge i_clk); while (!c_if.ready);
        if (idx == CFG_FWD_OFFSET) fwd_offset = longint'(v);
        else side_offset = longint'(v);
        @(negedge i_clk);
        c_if.valid = 1'b0;
    endtask

    task automatic report_field(input string what, input longint e, input longint a);
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %0d, actual %0d", what, e, a);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && r_if.valid && r_if.ready) begin
            if (expected_pose.size() == 0) begin
                report_field("unexpected result, pos_x", 0, $signed(r_if.data.pos_x));
            end else begin
                e = expected_pose.pop_front();
                if (r_if.data.pos_x !== e.pos_x)
                    report_field("pos_x", $signed(e.pos_x), $signed(r_if.data.pos_x));
                if (r_if.data.pos_y !== e.pos_y)
                    report_field("pos_y", $signed(e.pos_y), $signed(r_if.data.pos_y));
                if (r_if.data.heading_out !== e.heading_out)
                    report_field("heading_out", e.heading_out, r_if.data.heading_out);
            end
        end
    end

    // The receiver stalls in random bursts, and holds off for a long stretch on request.
    initial begin
        r_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                r_if.ready = 1'b0;
                repeat (600) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                r_if.ready = 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge i_clk);
            end else begin
                r_if.ready = 1'b1;
            end
        end
    end

    initial begin
        t_sample smp;
        t_result none;
        logic signed [15:0] fwd_set [0:4];
        logic signed [15:0] side_set [0:4];
        int unsigned f_walk, s_walk, h_walk, pick;
        cycles = 0;
        errors = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        none = '0;
        i_rst_n = 1'b0;
        s_if.valid = 1'b0;
        s_if.data = '0;
        c_if.valid = 1'b0;
        c_if.data = '0;
        fwd_offset = 320;
        side_offset = 742;
        prev_fwd = 0;
        prev_strafe = 0;
        prev_hdg = 0;
        field_x = 0;
        field_y = 0;
        fwd_set = '{16'sd320, 16'sh7FFF, -16'sh8000, 16'sd0, 16'($urandom)};
        side_set = '{16'sd742, -16'sh8000, 16'sh7FFF, 16'sd0, 16'($urandom)};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            smp.forward_angle = dir_tab[i].fwd;
            smp.strafe_angle = dir_tab[i].strafe;
            smp.gyro_heading = dir_tab[i].hdg;
            offer_sample(smp, dir_tab[i].known, dir_tab[i].res);
        end

        f_walk = 0;
        s_walk = 0;
        h_walk = 0;
        for (int ph = 0; ph < 5; ph++) begin
            drain_results();
            write_offset(CFG_FWD_OFFSET, fwd_set[ph]);
            write_offset(CFG_SIDE_OFFSET, side_set[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 5) hold_req = 1'b1;
                if (ph == 2 && n == 100) drain_results();
                if (ph == 4 && n == PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    f_walk = f_walk + $urandom_range(0, 8000) - 4000;
                    s_walk = s_walk + $urandom_range(0, 8000) - 4000;
                    h_walk = (h_walk + 36000 + $urandom_range(0, 3000) - 1500) % 36000;
                    if ($urandom_range(0, 7) == 0) h_walk = (h_walk + 36000 - 1) % 36000;
                end else if (pick < 18) begin
                    f_walk = $urandom;
                    s_walk = $urandom;
                    h_walk = $urandom_range(0, 35999);
                end else begin
                    f_walk = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
                    s_walk = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
                    h_walk = $urandom_range(0, 65535);
                end
                smp.forward_angle = f_walk;
                smp.strafe_angle = s_walk;
                smp.gyro_heading = h_walk[15:0];
                h_walk = h_walk % 36000;
                offer_sample(smp, 1'b0, none);
            end
        end

        drain_results();
        repeat (200) @(negedge i_clk);
        if (errors == 0 && expected_pose.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
